// ===== design/tlpq_pkg.sv =====
// Shared types and constants for the three-lane priority queue with aging.
package tlpq_pkg;

  // Default sizing
  localparam int unsigned LaneDepthDef = 16;
  localparam int unsigned NumLanesDef  = 3;

  // Fixed field widths
  localparam int unsigned SeqW   = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned IdW    = 32;
  localparam int unsigned LaneW  = 2;
  localparam int unsigned TotalW = 6;

  // Dispatch phase on which the oldest head is served
  localparam logic [PhaseW-1:0] PhaseOldest = 3'd7;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TAKE    = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_REJECTED   = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  // One stored entry: sequence stamp over token
  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [IdW-1:0]  id;
  } entry_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    out_work_id;
    logic [LaneW-1:0]  out_lane;
    logic [TotalW-1:0] queued_total;
  } res_t;

  // True when sequence a is older than sequence b, modulo 2^8
  function automatic logic seq_older(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] diff;
    diff = a - b;
    return diff[SeqW-1];
  endfunction

endpackage

// ===== design/tlpq_if.sv =====
// Handshake channels for request items and result items.
interface tlpq_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  priority_req;
  logic [31:0] work_id;

  modport source (output valid, output opcode, output priority_req, output work_id,
                  input ready);
  modport sink   (input valid, input opcode, input priority_req, input work_id,
                  output ready);
endinterface

interface tlpq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_work_id;
  logic [1:0]  out_lane;
  logic [5:0]  queued_total;

  modport source (output valid, output status, output out_work_id, output out_lane,
                  output queued_total, input ready);
  modport sink   (input valid, input status, input out_work_id, input out_lane,
                  input queued_total, output ready);
endinterface

// ===== design/three_lane_priority_queue_aging_top.sv =====
// Priority work queue: lane FIFOs in one memory, strict priority with periodic oldest-first.
//
// Request channel in_i carries opcode, priority_req and work_id; every request item
// yields exactly one result item on out_o (status, out_work_id, out_lane, queued_total).
// An enqueue stamps the token with a running 8-bit sequence and appends it to its lane.
// A take serves the lowest-numbered non-empty lane, except on every eighth dispatch,
// where it serves the lane whose head carries the oldest sequence stamp.
// Enqueue, rejected enqueue and empty take finish in the cycle they are accepted;
// a normal take does one read of the lane head from the entry memory, then finishes;
// an oldest-first take does one head read per lane through the single read port
// of the entry memory. One item is in work at a time.
// The result enters an output register; the next request is accepted while that
// result still waits. If the receiver stalls and the output register is full, a
// finished result parks in a hold register and requests stop until it moves on.
// Reset clears head pointers, fill counts, the sequence and the dispatch phase;
// the entry memory is not cleared, since no unwritten entry's data is ever used.
module three_lane_priority_queue_aging_top #(
  parameter int unsigned LANE_DEPTH = tlpq_pkg::LaneDepthDef,
  parameter int unsigned NUM_LANES  = tlpq_pkg::NumLanesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlpq_req_if.sink          in_i,
  tlpq_res_if.source        out_o
);

  localparam int unsigned Entries = NUM_LANES * LANE_DEPTH;
  localparam int unsigned AW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned LW  = $clog2(NUM_LANES);
  localparam int unsigned HW  = $clog2(LANE_DEPTH);
  localparam int unsigned CW  = $clog2(LANE_DEPTH + 1);
  localparam int unsigned SW  = HW + 1;
  localparam int unsigned TW  = $clog2(Entries + 1);
  localparam int unsigned SQW = tlpq_pkg::SeqW;
  localparam int unsigned IW  = tlpq_pkg::IdW;

  // Control state
  tlpq_pkg::state_e state_q, state_d;
  logic [HW-1:0]    head_q  [NUM_LANES];
  logic [CW-1:0]    count_q [NUM_LANES];
  logic [TW-1:0]    total_q;
  logic [SQW-1:0]   seq_q;
  logic [tlpq_pkg::PhaseW-1:0] phase_q;
  logic             out_valid_q, out_valid_d;

  // Scan and result payload
  logic             scan_all_q, scan_all_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [LW-1:0]    best_q, best_d;
  logic [SQW-1:0]   best_seq_q, best_seq_d;
  logic [IW-1:0]    best_id_q, best_id_d;
  logic             have_best_q, have_best_d;
  tlpq_pkg::res_t   res_q, res_d;
  tlpq_pkg::res_t   out_data_q, out_data_d;

  // Entry memory
  tlpq_pkg::entry_t mem_q [Entries];
  tlpq_pkg::entry_t rd_data_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tlpq_pkg::entry_t wr_data;

  // Step controls
  logic             in_ready;
  logic             accept;
  logic             slot_free;
  logic             fin;
  tlpq_pkg::res_t   fin_res;
  logic             push;
  logic             pop;
  logic [LW-1:0]    upd_lane;
  logic             out_load;

  assign in_ready  = (state_q == tlpq_pkg::S_IDLE);
  assign accept    = in_i.valid && in_ready;
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_data_q.status;
  assign out_o.out_work_id  = out_data_q.out_work_id;
  assign out_o.out_lane     = out_data_q.out_lane;
  assign out_o.queued_total = out_data_q.queued_total;

  // Memory address of a slot within a lane
  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lane,
                                              input logic [HW-1:0] slot);
    return AW'(32'(lane) * LANE_DEPTH + 32'(slot));
  endfunction

  // Decide the step: enqueue or reject, answer an empty take, start or advance a head scan, or hold a result
  always_comb begin
    logic [LW-1:0] in_lane;
    logic [LW-1:0] first_lane;
    logic [SW-1:0] tail;
    logic          cand;
    logic          last;
    logic [LW-1:0] pick_lane;
    logic [IW-1:0] pick_id;

    state_d     = state_q;
    scan_all_d  = scan_all_q;
    cur_d       = cur_q;
    best_d      = best_q;
    best_seq_d  = best_seq_q;
    best_id_d   = best_id_q;
    have_best_d = have_best_q;
    res_d       = res_q;
    fin         = 1'b0;
    fin_res     = '0;
    push        = 1'b0;
    pop         = 1'b0;
    upd_lane    = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    in_lane = LW'(in_i.priority_req);
    tail    = '0;
    cand    = 1'b0;
    last    = 1'b0;
    pick_lane = best_q;
    pick_id   = best_id_q;

    // Lowest-numbered non-empty lane
    first_lane = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        first_lane = LW'(i);
      end
    end

    case (state_q)
      tlpq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_i.opcode == tlpq_pkg::OP_ENQUEUE) begin
            fin = 1'b1;
            if (32'(in_i.priority_req) >= 32'(NUM_LANES)) begin
              fin_res.status       = tlpq_pkg::ST_REJECTED;
              fin_res.queued_total = tlpq_pkg::TotalW'(total_q);
            end else if (count_q[in_lane] == CW'(LANE_DEPTH)) begin
              fin_res.status       = tlpq_pkg::ST_REJECTED;
              fin_res.out_lane     = in_i.priority_req;
              fin_res.queued_total = tlpq_pkg::TotalW'(total_q);
            end else begin
              // Append at head + count, wrapped into the lane
              tail = SW'(head_q[in_lane]) + SW'(count_q[in_lane]);
              if (tail >= SW'(LANE_DEPTH)) begin
                tail = tail - SW'(LANE_DEPTH);
              end
              wr_en        = 1'b1;
              wr_addr      = slot_addr(in_lane, HW'(tail));
              wr_data.seq  = seq_q;
              wr_data.id   = in_i.work_id;
              push         = 1'b1;
              upd_lane     = in_lane;
              fin_res.status       = tlpq_pkg::ST_ENQUEUED;
              fin_res.out_lane     = in_i.priority_req;
              fin_res.queued_total = tlpq_pkg::TotalW'(total_q + TW'(1));
            end
          end else if (total_q == '0) begin
            fin                  = 1'b1;
            fin_res.status       = tlpq_pkg::ST_EMPTY;
            fin_res.queued_total = tlpq_pkg::TotalW'(total_q);
          end else begin
            // Start a head read: all lanes on the oldest-first phase, else one
            scan_all_d  = (phase_q == tlpq_pkg::PhaseOldest);
            cur_d       = (phase_q == tlpq_pkg::PhaseOldest) ? '0 : first_lane;
            have_best_d = 1'b0;
            rd_en       = 1'b1;
            rd_addr     = slot_addr(cur_d, head_q[cur_d]);
            state_d     = tlpq_pkg::S_SCAN;
          end
        end
      end

      tlpq_pkg::S_SCAN: begin
        // Keep the head if its lane holds items and it is older than the best so far
        cand = (count_q[cur_q] != '0) &&
               (!have_best_q || tlpq_pkg::seq_older(rd_data_q.seq, best_seq_q));
        last = !scan_all_q || (cur_q == LW'(NUM_LANES - 1));
        if (cand) begin
          pick_lane = cur_q;
          pick_id   = rd_data_q.id;
        end
        if (last) begin
          fin                  = 1'b1;
          pop                  = 1'b1;
          upd_lane             = pick_lane;
          fin_res.status       = tlpq_pkg::ST_DISPATCHED;
          fin_res.out_work_id  = pick_id;
          fin_res.out_lane     = tlpq_pkg::LaneW'(pick_lane);
          fin_res.queued_total = tlpq_pkg::TotalW'(total_q - TW'(1));
        end else begin
          if (cand) begin
            best_d      = cur_q;
            best_seq_d  = rd_data_q.seq;
            best_id_d   = rd_data_q.id;
            have_best_d = 1'b1;
          end
          cur_d   = cur_q + LW'(1);
          rd_en   = 1'b1;
          rd_addr = slot_addr(cur_d, head_q[cur_d]);
        end
      end

      tlpq_pkg::S_HOLD: begin
        if (slot_free) begin
          state_d = tlpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tlpq_pkg::S_IDLE;
      end
    endcase

    // Finish: straight into the output register, or park until it frees up
    if (fin) begin
      if (slot_free) begin
        state_d = tlpq_pkg::S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = tlpq_pkg::S_HOLD;
      end
    end
  end

  // Output register load
  always_comb begin
    out_load    = slot_free && (fin || (state_q == tlpq_pkg::S_HOLD));
    out_data_d  = (state_q == tlpq_pkg::S_HOLD) ? res_q : fin_res;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlpq_pkg::S_IDLE;
      total_q     <= '0;
      seq_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // Advance on enqueue
      if (push) begin
        count_q[upd_lane] <= count_q[upd_lane] + CW'(1);
        total_q           <= total_q + TW'(1);
        seq_q             <= seq_q + SQW'(1);
      end
      // Drop the served head
      if (pop) begin
        head_q[upd_lane]  <= (head_q[upd_lane] == HW'(LANE_DEPTH - 1)) ? '0
                                                                        : head_q[upd_lane] + HW'(1);
        count_q[upd_lane] <= count_q[upd_lane] - CW'(1);
        total_q           <= total_q - TW'(1);
        phase_q           <= phase_q + tlpq_pkg::PhaseW'(1);
      end
    end
  end

  // Scan and result payload registers
  always_ff @(posedge clk_i) begin
    scan_all_q  <= scan_all_d;
    cur_q       <= cur_d;
    best_q      <= best_d;
    best_seq_q  <= best_seq_d;
    best_id_q   <= best_id_d;
    have_best_q <= have_best_d;
    res_q       <= res_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== design/tlpq_checker.sv =====
// Port-level checks for the priority queue top level, attached by bind.
module tlpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] out_work_id_i,
  input logic [1:0]  out_lane_i,
  input logic [5:0]  queued_total_i
);

  // Hold a stalled result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_work_id_i) && $stable(out_lane_i) && $stable(queued_total_i))
    else $error("stalled result item changed");

  // Only a dispatch carries a token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != tlpq_pkg::ST_DISPATCHED) |-> out_work_id_i == '0)
    else $error("token on a non-dispatch result");

  // An empty take reports nothing held and no lane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == tlpq_pkg::ST_EMPTY) |-> queued_total_i == '0 &&
      out_lane_i == '0)
    else $error("empty take with items held");

  // A dispatch never wraps the item count below zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == tlpq_pkg::ST_DISPATCHED) |-> queued_total_i != 6'd63)
    else $error("dispatch left a wrapped item count");

endmodule

bind three_lane_priority_queue_aging_top tlpq_checker u_tlpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .out_work_id_i  (out_o.out_work_id),
  .out_lane_i     (out_o.out_lane),
  .queued_total_i (out_o.queued_total)
);
